// ----- rtl/core/utf8_codepoint_decoder_top_defines.svh -----
`ifndef UTF8_CODEPOINT_DECODER_TOP_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define U8D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, checked while out of reset.
`define U8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

// ----- rtl/core/utf8d_pkg.sv -----
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam logic [2:0]  MAX_FOLLOW   = 3'd5;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h3f;
  localparam logic [31:0] TRUNC_CODE   = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] code_point;
    logic        truncated;
  } result_t;

  // Lead-byte prefix mask after the given number of following bytes.
  function automatic logic [7:0] lead_mask(input logic [2:0] n);
    logic [7:0] m;
    case (n)
      3'd1:    m = 8'he0;
      3'd2:    m = 8'hf0;
      3'd3:    m = 8'hf8;
      3'd4:    m = 8'hfc;
      default: m = 8'hfe;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/utf8d_in_reg.sv -----
`timescale 1ns / 1ps

module utf8d_in_reg
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  input  logic       take,
  output logic       advance,
  output item_t      item
);

  logic item_valid;

  assign in_stall = item_valid && !take;
  assign advance  = item_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Hold the word while the decode stage cannot move.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.data_byte     <= data_byte;
      item.end_of_string <= end_of_string;
    end
  end

endmodule

// ----- rtl/core/utf8d_step.sv -----
`timescale 1ns / 1ps

module utf8d_step
  import utf8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  logic [7:0]  lead_byte;
  logic [7:0]  lead_byte_next;
  logic [2:0]  bytes_taken;
  logic [2:0]  bytes_taken_next;
  logic [31:0] accumulator;
  logic [31:0] accumulator_next;

  logic [2:0]  n;
  logic [7:0]  mask;
  logic        matched;
  logic [4:0]  shamt;
  logic [31:0] acc_or;
  logic [31:0] acc_shift;
  logic [31:0] cp_match;

  always_comb begin
    n         = (bytes_taken > MAX_FOLLOW) ? MAX_FOLLOW : bytes_taken;
    mask      = lead_mask(n);
    matched   = (lead_byte & mask) == {mask[6:0], 1'b0};
    shamt     = {n, 2'b00} + {1'b0, n, 1'b0};
    acc_or    = accumulator | 32'(item.data_byte & PAYLOAD_MASK);
    acc_shift = {acc_or[25:0], 6'd0};
    cp_match  = acc_or | (32'(lead_byte & ~mask) << shamt);
  end

  always_comb begin
    lead_byte_next   = lead_byte;
    bytes_taken_next = bytes_taken;
    accumulator_next = accumulator;
    res.emit         = 1'b0;
    res.code_point   = TRUNC_CODE;
    res.truncated    = 1'b0;
    if (bytes_taken == 3'd0) begin
      if (!item.data_byte[7]) begin
        res.emit       = 1'b1;
        res.code_point = 32'(item.data_byte);
      end else if (item.end_of_string) begin
        res.emit      = 1'b1;
        res.truncated = 1'b1;
      end else begin
        lead_byte_next   = item.data_byte;
        accumulator_next = '0;
        bytes_taken_next = 3'd1;
      end
    end else begin
      if (matched || n >= MAX_FOLLOW || item.end_of_string) begin
        // Sequence closes: either complete, six bytes long, or cut short.
        res.emit         = 1'b1;
        lead_byte_next   = '0;
        bytes_taken_next = '0;
        accumulator_next = '0;
        if (matched) begin
          res.code_point = cp_match;
        end else if (n >= MAX_FOLLOW) begin
          res.code_point = acc_shift;
        end else begin
          res.truncated = 1'b1;
        end
      end else begin
        accumulator_next = acc_shift;
        bytes_taken_next = n + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte   <= '0;
      bytes_taken <= '0;
      accumulator <= '0;
    end else if (advance) begin
      lead_byte   <= lead_byte_next;
      bytes_taken <= bytes_taken_next;
      accumulator <= accumulator_next;
    end
  end

endmodule

// ----- rtl/core/utf8d_out_reg.sv -----
`timescale 1ns / 1ps

module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  result_t     res,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] code_point,
  output logic        truncated
);

  logic load;

  // Free when empty or when the current word leaves this cycle.
  assign take = !out_valid || !out_stall;
  assign load = advance && res.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= res.code_point;
      truncated  <= res.truncated;
    end
  end

endmodule

// ----- rtl/core/utf8_codepoint_decoder_top.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Word
// -------  -------------------  ------------------------------
// input    in_valid / in_stall  data_byte[7:0], end_of_string
// output   out_valid/out_stall  code_point[31:0], truncated
//
// One byte per cycle unless stalled; a result is loaded as its last byte advances.
// Throughput is set by the single decode step between input and result register.
// rst clears the open sequence and both valid flags.
// in_stall rises only when the input register is full and the result register
// is full and stalled.

module utf8_codepoint_decoder_top
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] code_point,
  output logic        truncated
);

  logic    take;
  logic    advance;
  item_t   item;
  result_t res;

  utf8d_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .take          (take),
    .advance       (advance),
    .item          (item)
  );

  utf8d_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  utf8d_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .truncated  (truncated)
  );

endmodule

// ----- rtl/core/utf8d_checker.sv -----
`timescale 1ns / 1ps
`include "utf8_codepoint_decoder_top_defines.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        end_of_string,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] code_point,
  input logic        truncated
);

  `U8D_ASSERT_NEXT(a_in_hold, in_valid && in_stall, $stable({in_valid, data_byte, end_of_string}))
  `U8D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable({out_valid, code_point, truncated}))
  `U8D_ASSERT_NOW(a_trunc_ones, out_valid && truncated, code_point == 32'hffff_ffff)
  `U8D_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `U8D_ASSERT_NOW(a_rise_moves, $rose(out_valid), $past(!in_stall))

endmodule

bind utf8_codepoint_decoder_top utf8d_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .data_byte     (data_byte),
  .end_of_string (end_of_string),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .code_point    (code_point),
  .truncated     (truncated)
);
